### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When cond holds, nxt must hold in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

### rtl/core/lsec_pkg.sv
// ----------------------------------------------------------------------------
// lsec_pkg
// Types and constants shared by the scan classifier controller and datapath.
// ----------------------------------------------------------------------------
package lsec_pkg;

    localparam int THR_W      = 12;
    localparam int DENS_W     = 7;
    localparam int MAXR_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_PERCENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE       = 2'd2;

    localparam logic [THR_W-1:0]  RST_JUMP_THRESHOLD  = 12'd5;
    localparam logic [DENS_W-1:0] RST_DENSITY_PERCENT = 7'd40;
    localparam logic [MAXR_W-1:0] RST_MAX_RANGE       = 16'd30000;

    localparam int PCT_SCALE     = 100;
    localparam int JUMP_HIGH_PCT = 135;
    localparam int JUMP_LOW_PCT  = 65;

    localparam logic [1:0] CLS_NOTHING  = 2'd0;
    localparam logic [1:0] CLS_WALLS    = 2'd1;
    localparam logic [1:0] CLS_FEATURES = 2'd2;
    localparam logic [1:0] CLS_NONE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_END,
        S_MUL,
        S_MUL2,
        S_RES
    } t_state;

    typedef struct packed {
        logic capture;
        logic step;
        logic close;
        logic mult;
        logic scale;
        logic decide;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic nothing;
        logic out_busy;
    } t_dp_sts;

endpackage

### rtl/core/lsec_in_if.sv
// ----------------------------------------------------------------------------
// lsec_in_if
// Range sample channel: valid/ready handshake with sample payload.
// ----------------------------------------------------------------------------
interface lsec_in_if #(
    parameter int RANGE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_mm;
    logic                  scan_first;
    logic                  scan_last;

    modport source (output valid, output range_mm, output scan_first, output scan_last,
                    input ready);
    modport sink (input valid, input range_mm, input scan_first, input scan_last,
                  output ready);
endinterface

### rtl/core/lsec_out_if.sv
// ----------------------------------------------------------------------------
// lsec_out_if
// Classification result channel: valid/ready handshake with class payload.
// ----------------------------------------------------------------------------
interface lsec_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] env_class;
    logic       is_dense;

    modport source (output valid, output env_class, output is_dense, input ready);
    modport sink (input valid, input env_class, input is_dense, output ready);
endinterface

### rtl/core/laser_scan_environment_classifier_core.sv
// ----------------------------------------------------------------------------
// laser_scan_environment_classifier_core
// A sample without scan_last is captured with its range products, then compared.
// A sample with scan_last then goes through the window update and two multiply
// stages (skipped for a nothing-seen scan), plus any wait for the output register.
// One item at a time; ready is high only while the sequencer is idle.
// Synchronous active-low reset clears counts, sums, window fill and class; the
// window memory is not cleared, entries beyond the fill count read as zero.
// ----------------------------------------------------------------------------
module laser_scan_environment_classifier_core #(
    parameter int WINDOW_SCANS     = 100,
    parameter int MAX_SCAN_SAMPLES = 4096,
    parameter int RANGE_BITS       = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lsec_in_if.sink                         i_in_item,
    lsec_out_if.source                      o_res_item
);
    import lsec_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;
    logic [1:0] w_env_class;
    logic    w_is_dense;

    lsec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_item.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lsec_dp #(
        .WINDOW_SCANS     (WINDOW_SCANS),
        .MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES),
        .RANGE_BITS       (RANGE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_range_mm   (i_in_item.range_mm),
        .i_scan_first (i_in_item.scan_first),
        .i_scan_last  (i_in_item.scan_last),
        .i_out_ready  (o_res_item.ready),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (w_out_valid),
        .o_env_class  (w_env_class),
        .o_is_dense   (w_is_dense)
    );

    assign i_in_item.ready      = w_in_ready;
    assign o_res_item.valid     = w_out_valid;
    assign o_res_item.env_class = w_env_class;
    assign o_res_item.is_dense  = w_is_dense;

endmodule

### rtl/core/lsec_ctrl.sv
// ----------------------------------------------------------------------------
// lsec_ctrl
// Sequencer for sample compare, end-of-scan window update and result issue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsec_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lsec_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output lsec_pkg::t_dp_cmd o_cmd
);
    import lsec_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.scan_last ? S_END : S_IDLE;
            end
            S_END: begin
                o_cmd.close = 1'b1;
                n_state     = i_sts.nothing ? S_RES : S_MUL;
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (!i_sts.out_busy) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_to_cmp, i_in_valid && o_in_ready, r_state == S_CMP, "accept without compare")
    `ASSERT_NEXT(a_res_holds, (r_state == S_RES) && i_sts.out_busy, r_state == S_RES, "result lost while output busy")

endmodule

### rtl/core/lsec_dp.sv
// ----------------------------------------------------------------------------
// lsec_dp
// Datapath: jump/far counting, ring windows, cross-multiplied class decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsec_dp #(
    parameter int WINDOW_SCANS     = 100,
    parameter int MAX_SCAN_SAMPLES = 4096,
    parameter int RANGE_BITS       = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [RANGE_BITS-1:0]               i_range_mm,
    input  logic                                i_scan_first,
    input  logic                                i_scan_last,
    input  logic                                i_out_ready,
    input  lsec_pkg::t_dp_cmd                   i_cmd,
    output lsec_pkg::t_dp_sts                   o_sts,
    output logic                                o_out_valid,
    output logic [1:0]                          o_env_class,
    output logic                                o_is_dense
);
    import lsec_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SCAN_SAMPLES);
    localparam int SMP_W   = $clog2(MAX_SCAN_SAMPLES + 1);
    localparam int FILL_W  = $clog2(WINDOW_SCANS + 1);
    localparam int POS_W   = (WINDOW_SCANS > 1) ? $clog2(WINDOW_SCANS) : 1;
    localparam int SUM_W   = CNT_W + FILL_W;
    localparam int CMP_RW  = (RANGE_BITS > MAXR_W) ? RANGE_BITS : MAXR_W;
    localparam int PROD_W  = RANGE_BITS + 8;
    localparam int TF_W    = THR_W + FILL_W;
    localparam int JC_W    = (SUM_W > TF_W) ? SUM_W : TF_W;
    localparam int DF_W    = DENS_W + FILL_W;
    localparam int DFS_W   = DF_W + SMP_W;
    localparam int N100_W  = SUM_W + 7;
    localparam int DC_W    = (DFS_W > N100_W) ? DFS_W : N100_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_SCAN_SAMPLES - 1);
    localparam logic [SMP_W-1:0]  SMP_MAX  = SMP_W'(MAX_SCAN_SAMPLES);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_SCANS);
    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(WINDOW_SCANS - 1);

    logic [THR_W-1:0]      r_jump_thr;
    logic [DENS_W-1:0]     r_dens_pct;
    logic [MAXR_W-1:0]     r_max_range;

    logic [RANGE_BITS-1:0] r_prev;
    logic [CNT_W-1:0]      r_jump_cnt;
    logic [CNT_W-1:0]      r_far_cnt;
    logic [SMP_W-1:0]      r_samples;
    logic [SUM_W-1:0]      r_jump_sum;
    logic [SUM_W-1:0]      r_near_sum;
    logic [POS_W-1:0]      r_pos;
    logic [FILL_W-1:0]     r_fill;
    logic [1:0]            r_last_class;
    logic                  r_out_valid;

    logic [RANGE_BITS-1:0] r_range;
    logic                  r_first;
    logic                  r_last;
    logic [PROD_W-1:0]     r_p100;
    logic [PROD_W-1:0]     r_p135;
    logic [PROD_W-1:0]     r_p65;
    logic                  r_rfar;
    logic                  r_pfar;

    logic [CNT_W-1:0]      r_jump_mem [WINDOW_SCANS];
    logic [CNT_W-1:0]      r_near_mem [WINDOW_SCANS];
    logic [CNT_W-1:0]      r_jump_rd;
    logic [CNT_W-1:0]      r_near_rd;

    logic [TF_W-1:0]       r_thr_fill;
    logic [DF_W-1:0]       r_dens_fill;
    logic [N100_W-1:0]     r_near100;
    logic [DFS_W-1:0]      r_dens_fs;

    logic [1:0]            r_out_cls;
    logic                  r_out_dense;

    logic                  w_start;
    logic                  w_jump;
    logic [SMP_W-1:0]      w_compared;
    logic                  w_nothing;
    logic [CNT_W-1:0]      w_near;
    logic [CNT_W-1:0]      w_old_jump;
    logic [CNT_W-1:0]      w_old_near;
    logic [POS_W-1:0]      w_pos_next;
    logic                  w_wr;
    logic [1:0]            w_cls;
    logic                  w_dense;
    logic                  w_issue;

    always_comb begin
        w_start    = r_first || (r_samples == '0);
        w_jump     = (r_p100 > r_p135) || (r_p100 < r_p65);
        w_compared = r_samples - SMP_W'(1);
        w_nothing  = SMP_W'(r_far_cnt) >= w_compared;
        w_near     = CNT_W'(w_compared - SMP_W'(r_far_cnt));
        w_old_jump = (r_fill == FILL_MAX) ? r_jump_rd : '0;
        w_old_near = (r_fill == FILL_MAX) ? r_near_rd : '0;
        w_pos_next = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
        w_wr       = i_cmd.close && !w_nothing;
        if (w_nothing) begin
            w_cls = CLS_NOTHING;
        end else if (JC_W'(r_jump_sum) <= JC_W'(r_thr_fill)) begin
            w_cls = CLS_WALLS;
        end else begin
            w_cls = CLS_FEATURES;
        end
        w_dense = !w_nothing && (DC_W'(r_near100) > DC_W'(r_dens_fs));
        w_issue = i_cmd.decide && (w_cls != r_last_class);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_thr   <= RST_JUMP_THRESHOLD;
            r_dens_pct   <= RST_DENSITY_PERCENT;
            r_max_range  <= RST_MAX_RANGE;
            r_prev       <= '0;
            r_jump_cnt   <= '0;
            r_far_cnt    <= '0;
            r_samples    <= '0;
            r_jump_sum   <= '0;
            r_near_sum   <= '0;
            r_pos        <= '0;
            r_fill       <= '0;
            r_last_class <= CLS_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_JUMP_THRESHOLD:  r_jump_thr  <= i_cfg_data[THR_W-1:0];
                    CFG_DENSITY_PERCENT: r_dens_pct  <= i_cfg_data[DENS_W-1:0];
                    CFG_MAX_RANGE:       r_max_range <= i_cfg_data[MAXR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step) begin
                r_prev <= r_range;
                if (w_start) begin
                    r_jump_cnt <= '0;
                    r_far_cnt  <= '0;
                    r_samples  <= SMP_W'(1);
                end else begin
                    if (w_jump && !(r_rfar && r_pfar) && (r_jump_cnt < CNT_MAX)) begin
                        r_jump_cnt <= r_jump_cnt + CNT_W'(1);
                    end
                    if (r_rfar && (r_far_cnt < CNT_MAX)) begin
                        r_far_cnt <= r_far_cnt + CNT_W'(1);
                    end
                    if (r_samples < SMP_MAX) begin
                        r_samples <= r_samples + SMP_W'(1);
                    end
                end
            end
            if (w_wr) begin
                r_jump_sum <= r_jump_sum - SUM_W'(w_old_jump) + SUM_W'(r_jump_cnt);
                r_near_sum <= r_near_sum - SUM_W'(w_old_near) + SUM_W'(w_near);
                r_pos      <= w_pos_next;
                if (r_fill < FILL_MAX) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.decide) begin
                r_jump_cnt <= '0;
                r_far_cnt  <= '0;
                r_samples  <= '0;
            end
            if (w_issue) begin
                r_last_class <= w_cls;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_range <= i_range_mm;
            r_first <= i_scan_first;
            r_last  <= i_scan_last;
            r_p100  <= PROD_W'(i_range_mm) * PROD_W'(PCT_SCALE);
            r_p135  <= PROD_W'(r_prev) * PROD_W'(JUMP_HIGH_PCT);
            r_p65   <= PROD_W'(r_prev) * PROD_W'(JUMP_LOW_PCT);
            r_rfar  <= CMP_RW'(i_range_mm) > CMP_RW'(r_max_range);
            r_pfar  <= CMP_RW'(r_prev) > CMP_RW'(r_max_range);
        end
        if (i_cmd.mult) begin
            r_thr_fill  <= TF_W'(r_jump_thr) * TF_W'(r_fill);
            r_dens_fill <= DF_W'(r_dens_pct) * DF_W'(r_fill);
            r_near100   <= N100_W'(r_near_sum) * N100_W'(PCT_SCALE);
        end
        if (i_cmd.scale) begin
            r_dens_fs <= DFS_W'(r_dens_fill) * DFS_W'(r_samples);
        end
        if (w_issue) begin
            r_out_cls   <= w_cls;
            r_out_dense <= w_dense;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_jump_mem[r_pos] <= r_jump_cnt;
            r_near_mem[r_pos] <= w_near;
        end
        r_jump_rd <= r_jump_mem[r_pos];
        r_near_rd <= r_near_mem[r_pos];
    end

    assign o_sts.scan_last = r_last;
    assign o_sts.nothing   = w_nothing;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_env_class     = r_out_cls;
    assign o_is_dense      = r_out_dense;

    `ASSERT_PROP(a_fill_tracks_pos, (r_fill < FILL_MAX) |-> (FILL_W'(r_pos) == r_fill), "ring position out of step with fill")
    `ASSERT_PROP(a_issue_on_change, $rose(r_out_valid) |-> (r_last_class != $past(r_last_class)), "result without class change")
    `ASSERT_PROP(a_jumps_bounded, (r_samples != '0) |-> (SMP_W'(r_jump_cnt) < r_samples), "jump count exceeds compared samples")

endmodule
